FILE: rtl/core/stack_machine_execute_unit_assert.svh
// Assertion macros shared by the stack machine execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sme_pkg.sv
// Shared types and constants for the stack machine execute unit.
package sme_pkg;

  localparam int SME_STACK_DEPTH = 256;
  localparam int WORD_W          = 32;
  localparam int DATA_W          = 30;
  localparam int DEPTH_W         = 9;

  localparam logic [1:0] TYPE_PRIM = 2'd1;

  localparam logic [DATA_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [DATA_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [DATA_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [DATA_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [DATA_W-1:0] PRIM_DIV  = 30'd4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_UNSUP = 3'd4
  } status_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

FILE: rtl/core/sme_stack.sv
// Stack word memory: one write port, one registered read port.
module sme_stack
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = SME_STACK_DEPTH,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sme_alu.sv
// Shared arithmetic unit: registered add/sub/mul, bit-serial signed divide.
module sme_alu
  import sme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_t;

  alu_state_t        state;
  logic [4:0]        step;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic              neg;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;

  assign mag_a   = req.a[WORD_W-1] ? (~req.a + 32'd1) : req.a;
  assign mag_b   = req.b[WORD_W-1] ? (~req.b + 32'd1) : req.b;
  assign shifted = {rem, quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      // add, sub and mul finish at once, divide finishes after the sign fix
      rsp.done <= (state == A_FIX) ||
                  ((state == A_IDLE) && req.start && (req.op != OP_DIV));
      case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              OP_ADD: begin
                rsp.result <= req.a + req.b;
              end
              OP_SUB: begin
                rsp.result <= req.a - req.b;
              end
              OP_MUL: begin
                rsp.result <= req.a * req.b;
              end
              OP_DIV: begin
                rem   <= '0;
                quo   <= mag_a;
                dvs   <= mag_b;
                neg   <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
                step  <= 5'd31;
                state <= A_DIV;
              end
              default: begin
                rsp.result <= '0;
              end
            endcase
          end
        end
        A_DIV: begin
          // restoring step: one quotient bit per cycle
          if (!diff[WORD_W]) begin
            rem <= diff[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b1};
          end else begin
            rem <= shifted[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b0};
          end
          if (step == 5'd0) begin
            state <= A_FIX;
          end else begin
            step <= step - 5'd1;
          end
        end
        A_FIX: begin
          rsp.result <= neg ? (~quo + 32'd1) : quo;
          state      <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/stack_machine_execute_unit.sv
// Channel   Handshake                    Payload
// instr     instr_valid / instr_ready    instr_word
// result    result_valid / result_ready  top_value, depth, halted, status
//
// One instruction at a time; instr_ready is high only while the sequencer idles.
// Push, halt and rejected items go from idle straight to the done state and the result register.
// Add, sub, mul pass through stack read, ALU op, write-back and result.
// Divide waits on the one-bit-per-cycle divider; divide by zero goes from the stack read to done.
// Reset clears depth and halt state; no memory clear pass.
// A stalled result holds the sequencer after the next transaction is taken.
module stack_machine_execute_unit
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = SME_STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                instr_valid,
  output logic                instr_ready,
  input  logic [WORD_W-1:0]   instr_word,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [WORD_W-1:0] top_value,
  output logic [DEPTH_W-1:0]  depth,
  output logic                halted,
  output logic [2:0]          status
);

  `include "stack_machine_execute_unit_assert.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_DONE
  } seq_state_t;

  seq_state_t        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m2;
  logic              halt_flag;
  logic [WORD_W-1:0] top_word;
  alu_op_t           op_reg;
  status_t           st_pend;

  logic              acc;
  logic [1:0]        typ;
  logic [DATA_W-1:0] dat;
  logic              is_arith;
  logic              full;
  logic              short;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [WORD_W-1:0] rd_data;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign instr_ready = (state == S_IDLE);
  assign acc         = instr_valid && instr_ready;
  assign typ         = instr_word[WORD_W-1:DATA_W];
  assign dat         = instr_word[DATA_W-1:0];
  assign is_arith    = (typ == TYPE_PRIM) && (dat >= PRIM_ADD) && (dat <= PRIM_DIV);
  assign full        = (count == CW'(STACK_DEPTH));
  assign short       = (count < CW'(2));
  assign cnt_m2      = count - CW'(2);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = WORD_W'(dat);
    rd_en   = 1'b0;
    if (acc && !halt_flag) begin
      if (typ != TYPE_PRIM && !full) begin
        wr_en = 1'b1;
      end
      if (is_arith && !short) begin
        rd_en = 1'b1;
      end
    end
    // write the result over the lower operand
    if (state == S_WAIT && alu_rsp.done) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m2[AW-1:0];
      wr_data = alu_rsp.result;
    end
  end

  always_comb begin
    alu_req.start = (state == S_READ) && !(op_reg == OP_DIV && top_word == '0);
    alu_req.op    = op_reg;
    alu_req.a     = rd_data;
    alu_req.b     = top_word;
  end

  sme_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(cnt_m2[AW-1:0]),
    .rd_data(rd_data)
  );

  sme_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      halt_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // in S_DONE a new transaction takes the slot being drained
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (halt_flag) begin
              st_pend <= ST_UNSUP;
              state   <= S_DONE;
            end else if (typ != TYPE_PRIM) begin
              state <= S_DONE;
              if (full) begin
                st_pend <= ST_OVER;
              end else begin
                st_pend  <= ST_OK;
                top_word <= WORD_W'(dat);
                count    <= count + CW'(1);
              end
            end else if (dat == PRIM_HALT) begin
              st_pend   <= ST_OK;
              halt_flag <= 1'b1;
              state     <= S_DONE;
            end else if (dat > PRIM_DIV) begin
              st_pend <= ST_UNSUP;
              state   <= S_DONE;
            end else if (short) begin
              st_pend <= ST_UNDER;
              state   <= S_DONE;
            end else begin
              case (dat)
                PRIM_ADD: op_reg <= OP_ADD;
                PRIM_SUB: op_reg <= OP_SUB;
                PRIM_MUL: op_reg <= OP_MUL;
                default:  op_reg <= OP_DIV;
              endcase
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (op_reg == OP_DIV && top_word == '0) begin
            st_pend <= ST_DIVZ;
            state   <= S_DONE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            top_word <= alu_rsp.result;
            count    <= count - CW'(1);
            st_pend  <= ST_OK;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!result_valid || result_ready) begin
            top_value    <= (count != '0) ? top_word : '0;
            depth        <= DEPTH_W'(count);
            halted       <= halt_flag;
            status       <= st_pend;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SME_ASSERT_IMP(a_alu_done_in_wait, alu_rsp.done, state == S_WAIT, "ALU done outside wait")
  `SME_ASSERT_NXT(a_halt_sticky, halt_flag, halt_flag, "halt flag cleared without reset")
  `SME_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH), "stack count past depth")
  `SME_ASSERT_NXT(a_halted_no_change, acc && halt_flag, $stable(count) && state == S_DONE, "stack changed after halt")

endmodule

FILE: tb/stack_machine_execute_unit_tb.sv
// Testbench for the stack machine execute unit: shadow stack predictor and per-result checks.
`timescale 1ns / 1ps

module stack_machine_execute_unit_tb
  import sme_pkg::*;
();

  localparam int STACK_DEPTH     = SME_STACK_DEPTH;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 60;

  localparam logic [1:0] TYPE_POS  = 2'd0;
  localparam logic [1:0] TYPE_NEG  = 2'd2;
  localparam logic [1:0] TYPE_CHAR = 2'd3;

  localparam logic [DATA_W-1:0] PRIM_STR_FIRST = 30'd9;
  localparam logic [DATA_W-1:0] PRIM_STR_LAST  = 30'd10;
  localparam logic [DATA_W-1:0] PRIM_FIRST_BAD = 30'd5;
  localparam logic [DATA_W-1:0] DATA_ALL_ONES  = 30'h3fffffff;

  typedef struct {
    logic [WORD_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    logic               halted;
    status_t            status;
  } machine_view_t;

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     instr_valid  = 1'b0;
  logic                     instr_ready;
  logic [WORD_W-1:0]        instr_word   = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  logic signed [WORD_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic                     halted;
  logic [2:0]               status;

  // shadow copy of the machine
  logic [WORD_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_count  = 0;
  bit                shadow_halted = 1'b0;
  machine_view_t     expected_views [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned peak_depth     = 0;
  int unsigned status_hits [5] = '{default: 0};

  stack_machine_execute_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr_word   (instr_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .top_value    (top_value),
    .depth        (depth),
    .halted       (halted),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed quotient, truncated toward zero, wrapped to 32 bits.
  function automatic logic [WORD_W-1:0] signed_quotient(input logic [WORD_W-1:0] num,
                                                        input logic [WORD_W-1:0] den);
    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;
    logic [WORD_W-1:0] quo;
    num_mag = num[WORD_W-1] ? (32'd0 - num) : num;
    den_mag = den[WORD_W-1] ? (32'd0 - den) : den;
    quo     = num_mag / den_mag;
    return (num[WORD_W-1] != den[WORD_W-1]) ? (32'd0 - quo) : quo;
  endfunction

  function automatic void predict_instr(input logic [WORD_W-1:0] word);
    machine_view_t     view;
    logic [1:0]        kind;
    logic [DATA_W-1:0] arg;
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] res;
    status_t           st;
    kind = word[WORD_W-1:DATA_W];
    arg  = word[DATA_W-1:0];
    st   = ST_OK;
    res  = '0;
    if (shadow_halted) begin
      st = ST_UNSUP;
    end else if (kind != TYPE_PRIM) begin
      if (shadow_count >= STACK_DEPTH) begin
        st = ST_OVER;
      end else begin
        shadow_stack[shadow_count] = {2'b00, arg};
        shadow_count++;
      end
    end else if (arg == PRIM_HALT) begin
      shadow_halted = 1'b1;
    end else if (arg > PRIM_DIV) begin
      st = ST_UNSUP;
    end else if (shadow_count < 2) begin
      st = ST_UNDER;
    end else begin
      upper = shadow_stack[shadow_count-1];
      lower = shadow_stack[shadow_count-2];
      case (arg)
        PRIM_ADD: res = lower + upper;
        PRIM_SUB: res = lower - upper;
        PRIM_MUL: res = lower * upper;
        default: begin
          if (upper == '0) st = ST_DIVZ;
          else res = signed_quotient(lower, upper);
        end
      endcase
      if (st == ST_OK) begin
        shadow_stack[shadow_count-2] = res;
        shadow_count--;
      end
    end
    view.top    = (shadow_count > 0) ? shadow_stack[shadow_count-1] : '0;
    view.depth  = shadow_count[DEPTH_W-1:0];
    view.halted = shadow_halted;
    view.status = st;
    expected_views.push_back(view);
    status_hits[st]++;
    if (shadow_count > peak_depth) peak_depth = shadow_count;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got, want);
    mismatch_count++;
  endtask

  // Check the result first, then predict the transaction taken on the same edge.
  always @(posedge clk) begin : result_check
    machine_view_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected result", top_value, '0);
        end else begin
          want = expected_views.pop_front();
          if (top_value !== want.top) report_mismatch("top_value", top_value, want.top);
          if (depth !== want.depth) report_mismatch("depth", depth, want.depth);
          if (halted !== want.halted) report_mismatch("halted", halted, want.halted);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
        results_seen++;
      end
      if (instr_valid && instr_ready) predict_instr(instr_word);
    end
  end

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when nothing moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((instr_valid && instr_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_instr(input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_valid <= 1'b0;
      @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr_word  <= word;
    do @(posedge clk); while (!instr_ready);
  endtask

  task automatic push_word(input logic [1:0] kind, input logic [DATA_W-1:0] data);
    send_instr({kind, data});
  endtask

  task automatic run_prim(input logic [DATA_W-1:0] code);
    send_instr({TYPE_PRIM, code});
  endtask

  task automatic wait_drained();
    instr_valid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [DATA_W-1:0] random_data();
    logic [DATA_W-1:0] d;
    case ($urandom_range(7))
      0:       d = '0;
      1:       d = DATA_ALL_ONES;
      2:       d = DATA_W'($urandom_range(1, 16));
      3:       d = DATA_W'($urandom_range(0, 1023));
      default: d = DATA_W'($urandom);
    endcase
    return d;
  endfunction

  function automatic logic [1:0] random_kind();
    logic [1:0] k;
    case ($urandom_range(2))
      0:       k = TYPE_POS;
      1:       k = TYPE_NEG;
      default: k = TYPE_CHAR;
    endcase
    return k;
  endfunction

  function automatic logic [DATA_W-1:0] random_arith();
    logic [DATA_W-1:0] op;
    case ($urandom_range(3))
      0:       op = PRIM_ADD;
      1:       op = PRIM_SUB;
      2:       op = PRIM_MUL;
      default: op = PRIM_DIV;
    endcase
    return op;
  endfunction

  function automatic logic [DATA_W-1:0] random_bad_prim();
    logic [DATA_W-1:0] code;
    case ($urandom_range(3))
      0:       code = PRIM_STR_FIRST;
      1:       code = PRIM_STR_LAST;
      2:       code = DATA_W'($urandom_range(PRIM_FIRST_BAD, PRIM_STR_FIRST - 1));
      default: code = DATA_W'($urandom);
    endcase
    if (code < PRIM_FIRST_BAD) code = code + PRIM_FIRST_BAD;
    return code;
  endfunction

  // Wrap, most negative over minus one, divide by zero, underflow, unknown codes.
  task automatic test_directed_corners();
    run_prim(PRIM_ADD);
    push_word(TYPE_POS, '0);
    run_prim(PRIM_MUL);
    push_word(TYPE_NEG, DATA_ALL_ONES);
    push_word(TYPE_CHAR, DATA_ALL_ONES);
    run_prim(PRIM_MUL);
    push_word(TYPE_POS, 30'd1);
    run_prim(PRIM_SUB);
    push_word(TYPE_POS, '0);
    push_word(TYPE_CHAR, 30'd1);
    run_prim(PRIM_SUB);
    run_prim(PRIM_DIV);
    push_word(TYPE_NEG, '0);
    run_prim(PRIM_DIV);
    run_prim(PRIM_ADD);
    push_word(TYPE_POS, 30'd7);
    run_prim(PRIM_SUB);
    run_prim(PRIM_SUB);
    push_word(TYPE_POS, 30'd2);
    run_prim(PRIM_DIV);
    push_word(TYPE_POS, '0);
    push_word(TYPE_CHAR, 30'd5);
    run_prim(PRIM_SUB);
    run_prim(PRIM_DIV);
    run_prim(PRIM_STR_FIRST);
    run_prim(PRIM_STR_LAST);
    run_prim(DATA_ALL_ONES);
  endtask

  // Random walk over the stack, kept mostly shallow.
  task automatic test_random_ops(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        run_prim(random_bad_prim());
      end else if (roll < 13) begin
        push_word(random_kind(), '0);
        run_prim(PRIM_DIV);
      end else if ((shadow_count < 2 && roll < 80) || (shadow_count < 40 && roll < 55)) begin
        push_word(random_kind(), random_data());
      end else begin
        run_prim(random_arith());
      end
    end
  endtask

  // Fill to the top, push past it, then fold the stack back down.
  task automatic test_stack_overflow();
    while (shadow_count < STACK_DEPTH) push_word(random_kind(), random_data());
    repeat (3) push_word(random_kind(), random_data());
    run_prim(random_arith());
    push_word(random_kind(), random_data());
    push_word(random_kind(), random_data());
    while (shadow_count > 1) run_prim(random_arith());
  endtask

  // After halt every transaction leaves the stack unchanged and is reported unsupported.
  task automatic test_halt_lockout();
    push_word(TYPE_POS, random_data());
    push_word(TYPE_NEG, random_data());
    run_prim(PRIM_HALT);
    push_word(TYPE_CHAR, random_data());
    run_prim(PRIM_ADD);
    run_prim(PRIM_DIV);
    run_prim(PRIM_HALT);
    run_prim(PRIM_STR_FIRST);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(0, 0);
    test_directed_corners();
    set_idling(75, 0);
    test_random_ops(130);
    // hold the sender until the pipe is empty
    wait_drained();
    set_idling(0, 75);
    test_random_ops(130);
    set_idling(27, 27);
    test_random_ops(130);
    set_idling(0, 0);
    test_random_ops(130);
    set_idling(27, 27);
    test_stack_overflow();
    set_idling(75, 0);
    test_halt_lockout();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d results, peak depth %0d, %0d mismatches", results_seen, peak_depth,
             mismatch_count);
    $display("status: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, unsupported %0d",
             status_hits[ST_OK], status_hits[ST_UNDER], status_hits[ST_OVER],
             status_hits[ST_DIVZ], status_hits[ST_UNSUP]);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
